// ===== design/u2u_pkg.sv =====
`default_nettype none

package u2u_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    // Lead byte thresholds and masks
    localparam logic [7:0] LEAD_3BYTE  = 8'hE0;
    localparam logic [7:0] LEAD_2BYTE  = 8'hC0;
    localparam logic [7:0] LEAD_CONT   = 8'h80;
    localparam logic [7:0] MASK_6BIT   = 8'h3F;
    localparam logic [7:0] MASK_4BIT   = 8'h0F;

    // Stored partial character: at most 4 + 6 bits before the last byte
    localparam int PART_W = 10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic        string_done;
    } t_out_item;

    // Decoder state: continuation bytes still owed, bits so far, sticky error
    typedef struct packed {
        logic              bad_lead;
        logic [1:0]        left;
        logic [PART_W-1:0] partial;
    } t_dec_state;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_step_result;

endpackage

`default_nettype wire

// ===== design/u2u_step.sv =====
`default_nettype none

// One decode step: current state plus one byte -> next state and optional result
module u2u_step (
    input  wire u2u_pkg::t_dec_state   i_state,
    input  wire u2u_pkg::t_in_item     i_item,
    output u2u_pkg::t_dec_state        o_state,
    output u2u_pkg::t_step_result      o_result
);
    import u2u_pkg::*;

    logic [7:0]  b;
    logic        eos;
    logic [15:0] joined;

    assign b      = i_item.data_byte;
    assign eos    = i_item.end_of_string;
    assign joined = {i_state.partial, b[5:0]};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.bad_lead) begin
            if (eos) begin
                o_state         = '0;
                o_result.valid  = 1'b1;
                o_result.item   = '{code_unit: 16'd0, status: ST_BAD_LEAD, string_done: 1'b1};
            end
        end else if (i_state.left == 2'd0) begin
            if (b < LEAD_CONT) begin
                o_result.valid = 1'b1;
                o_result.item  = '{code_unit: {8'd0, b}, status: ST_OK, string_done: eos};
            end else if (b < LEAD_2BYTE) begin
                o_state.bad_lead = 1'b1;
                if (eos) begin
                    o_state        = '0;
                    o_result.valid = 1'b1;
                    o_result.item  = '{code_unit: 16'd0, status: ST_BAD_LEAD,
                                       string_done: 1'b1};
                end
            end else begin
                if (b < LEAD_3BYTE) begin
                    o_state.left    = 2'd1;
                    o_state.partial = PART_W'(b & MASK_6BIT);
                end else begin
                    o_state.left    = 2'd2;
                    o_state.partial = PART_W'(b & MASK_4BIT);
                end
                if (eos) begin
                    o_state        = '0;
                    o_result.valid = 1'b1;
                    o_result.item  = '{code_unit: 16'd0, status: ST_TRUNCATED,
                                       string_done: 1'b1};
                end
            end
        end else if (i_state.left == 2'd1) begin
            // last continuation byte closes the character
            o_state        = '0;
            o_result.valid = 1'b1;
            o_result.item  = '{code_unit: joined, status: ST_OK, string_done: eos};
        end else begin
            o_state.left    = 2'd1;
            o_state.partial = joined[PART_W-1:0];
            if (eos) begin
                o_state        = '0;
                o_result.valid = 1'b1;
                o_result.item  = '{code_unit: 16'd0, status: ST_TRUNCATED, string_done: 1'b1};
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/u2u_out_reg.sv =====
`default_nettype none

// Result register; takes a new result whenever empty or being drained
module u2u_out_reg (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_load,
    input  wire u2u_pkg::t_out_item  i_item,
    output logic                     o_space,
    output logic                     o_valid,
    input  wire                      i_ready,
    output u2u_pkg::t_out_item       o_item
);
    import u2u_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_space = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== design/utf8_to_ucs2_decoder_top.sv =====
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+------------------------------------
// in       | input     | i_in_valid / o_in_ready | i_in_data: data_byte, end_of_string
// out      | output    | o_out_valid/ i_out_ready| o_out_data: code_unit, status, done
//
// One byte per clock sustained while the out side does not stall: input register -> decode step -> result register.
// Each byte is held in the input register; its result, if any, then loads the result register that drives o_out_valid.
// Synchronous active-low reset clears both valid flags and the decoder state.
// A stall on the out side backs up through the result register to o_in_ready;
// bytes that produce no result never wait on the out side's ready.
module utf8_to_ucs2_decoder_top (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire u2u_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output u2u_pkg::t_out_item       o_out_data
);
    import u2u_pkg::*;

    logic         r_in_valid;
    t_in_item     r_in;
    t_dec_state   r_state;
    t_dec_state   n_state;
    t_step_result step_res;
    logic         out_space;
    logic         advance;

    // the held byte moves on when its result (if any) has room
    assign advance    = r_in_valid && (!step_res.valid || out_space);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    u2u_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (step_res)
    );

    u2u_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && step_res.valid),
        .i_item  (step_res.item),
        .o_space (out_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

    // never more than two continuation bytes owed
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.left != 2'd3)
        else $error("continuation count out of range");

    // sticky error state never holds an open character
    a_bad_no_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bad_lead |-> (r_state.left == 2'd0))
        else $error("open character while error is sticky");

    // error results carry a zero code and close the string
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (o_out_data.code_unit == 16'd0 && o_out_data.string_done))
        else $error("malformed error result");

    // final byte of a string leaves the decoder clear
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.end_of_string) |=> (r_state == '0))
        else $error("state not cleared at end of string");

endmodule

`default_nettype wire
